// ----- rtl/bts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and byte classification for the byte stream
// tokenizer.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int MAX_TOKEN_LEN = 255;
   localparam int OFFSET_BITS   = 24;

   localparam int LEN_LIMIT = (MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN;
   localparam logic [23:0] OFF_MAX =
      (OFFSET_BITS >= 24) ? 24'hFFFFFF : 24'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [7:0] CHAR_SEMICOLON  = 8'h3B;

   localparam logic [3:0] KIND_IDENT     = 4'd0;
   localparam logic [3:0] KIND_NUMBER    = 4'd1;
   localparam logic [3:0] KIND_PLUS      = 4'd2;
   localparam logic [3:0] KIND_MINUS     = 4'd3;
   localparam logic [3:0] KIND_TIMES     = 4'd4;
   localparam logic [3:0] KIND_DIVIDE    = 4'd5;
   localparam logic [3:0] KIND_LPAREN    = 4'd6;
   localparam logic [3:0] KIND_RPAREN    = 4'd7;
   localparam logic [3:0] KIND_EQUALS    = 4'd8;
   localparam logic [3:0] KIND_SEMICOLON = 4'd9;
   localparam logic [3:0] KIND_END       = 4'd10;
   localparam logic [3:0] KIND_NONE      = 4'd0;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [23:0] start;
      logic [7:0]  length;
      logic        overflow;
   } token_type;

   typedef struct packed {
      token_type   first;
      token_type   second;
      logic [1:0]  count;
   } entry_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [3:0] op_kind(input logic [7:0] c);
      logic [3:0] k;
      unique case (c)
         CHAR_PLUS:      k = KIND_PLUS;
         CHAR_MINUS:     k = KIND_MINUS;
         CHAR_STAR:      k = KIND_TIMES;
         CHAR_SLASH:     k = KIND_DIVIDE;
         CHAR_LPAREN:    k = KIND_LPAREN;
         CHAR_RPAREN:    k = KIND_RPAREN;
         CHAR_EQUALS:    k = KIND_EQUALS;
         CHAR_SEMICOLON: k = KIND_SEMICOLON;
         default:        k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/bts_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_front
// Accepts text bytes, tracks position and open token, and packs the tokens
// that each byte completes into one queue entry.
// ----------------------------------------------------------------------------
module bts_front
   import bts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   scan_mode_type mode_ff, mode_in;
   logic [15:0]   line_ff, line_in;
   logic [15:0]   col_ff, col_in;
   logic [23:0]   off_ff, off_in;
   logic [15:0]   ostart_col_ff, ostart_col_in;
   logic [23:0]   ostart_off_ff, ostart_off_in;
   logic [7:0]    olen_ff, olen_in;

   logic          accept;
   logic          c_alpha, c_digit, c_nul;
   logic [3:0]    c_op;
   logic          cont;
   logic          grow_act;
   logic [7:0]    grow_base;
   logic [8:0]    grow_len;
   logic          grow_cut;
   logic [15:0]   grow_col;
   logic [23:0]   grow_off;
   scan_mode_type grow_mode;
   logic [15:0]   adv_line, adv_col;
   logic [23:0]   adv_off;

   logic          pend;
   token_type     pend_tok, other_tok;
   logic          other_v;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   assign c_alpha = is_alpha(req_char_byte);
   assign c_digit = is_digit(req_char_byte);
   assign c_nul   = (req_char_byte == CHAR_NUL);
   assign c_op    = op_kind(req_char_byte);

   always_comb begin
      unique case (mode_ff)
         MODE_IDENT:  cont = c_alpha || c_digit || (req_char_byte == CHAR_UNDERSCORE);
         MODE_NUMBER: cont = c_digit;
         default:     cont = 1'b0;
      endcase
   end

   // byte added to an open or new token
   assign grow_act  = cont || c_alpha || c_digit;
   assign grow_base = cont ? olen_ff : 8'd0;
   assign grow_len  = {1'b0, grow_base} + 9'd1;
   assign grow_cut  = grow_len >= 9'(LEN_LIMIT);
   assign grow_col  = (grow_base == 8'd0) ? col_ff : ostart_col_ff;
   assign grow_off  = (grow_base == 8'd0) ? off_ff : ostart_off_ff;
   assign grow_mode = cont ? mode_ff : (c_alpha ? MODE_IDENT : MODE_NUMBER);

   // position after a nonzero byte
   always_comb begin
      adv_off  = (off_ff < OFF_MAX) ? off_ff + 24'd1 : off_ff;
      adv_line = line_ff;
      adv_col  = col_ff;
      if (req_char_byte == CHAR_NEWLINE) begin
         adv_line = (line_ff < COUNT_MAX) ? line_ff + 16'd1 : line_ff;
         adv_col  = 16'd1;
      end else if (col_ff < COUNT_MAX) begin
         adv_col = col_ff + 16'd1;
      end
   end

   // next state
   always_comb begin
      mode_in       = mode_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      off_in        = off_ff;
      ostart_col_in = ostart_col_ff;
      ostart_off_in = ostart_off_ff;
      olen_in       = olen_ff;
      if (accept) begin
         priority if (!cont && c_nul) begin
            mode_in       = MODE_IDLE;
            line_in       = 16'd1;
            col_in        = 16'd1;
            off_in        = 24'd0;
            ostart_col_in = 16'd1;
            ostart_off_in = 24'd0;
            olen_in       = 8'd0;
         end else begin
            line_in = adv_line;
            col_in  = adv_col;
            off_in  = adv_off;
            if (grow_act) begin
               mode_in       = grow_mode;
               ostart_col_in = grow_col;
               ostart_off_in = grow_off;
               olen_in       = grow_cut ? 8'd0 : grow_len[7:0];
            end else begin
               mode_in = MODE_IDLE;
               olen_in = 8'd0;
            end
         end
      end
   end

   // tokens produced by this byte
   always_comb begin
      pend = !cont && (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER) && (olen_ff != 8'd0);
      pend_tok.kind     = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
      pend_tok.line     = line_ff;
      pend_tok.column   = ostart_col_ff;
      pend_tok.start    = ostart_off_ff;
      pend_tok.length   = olen_ff;
      pend_tok.overflow = 1'b0;

      other_v             = 1'b0;
      other_tok.kind      = c_op;
      other_tok.line      = line_ff;
      other_tok.column    = col_ff;
      other_tok.start     = off_ff;
      other_tok.length    = 8'd1;
      other_tok.overflow  = 1'b0;
      priority if (grow_act) begin
         other_v            = grow_cut;
         other_tok.kind     = (grow_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
         other_tok.column   = grow_col;
         other_tok.start    = grow_off;
         other_tok.length   = grow_len[7:0];
         other_tok.overflow = 1'b1;
      end else if (c_nul) begin
         other_v          = 1'b1;
         other_tok.kind   = KIND_END;
         other_tok.length = 8'd0;
      end else begin
         other_v = (c_op != KIND_NONE);
      end

      push_entry.first  = pend ? pend_tok : other_tok;
      push_entry.second = other_tok;
      push_entry.count  = {1'b0, pend} + {1'b0, other_v};
      push              = accept && (pend || other_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         line_ff       <= 16'd1;
         col_ff        <= 16'd1;
         off_ff        <= 24'd0;
         ostart_col_ff <= 16'd1;
         ostart_off_ff <= 24'd0;
         olen_ff       <= 8'd0;
      end else begin
         mode_ff       <= mode_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         off_ff        <= off_in;
         ostart_col_ff <= ostart_col_in;
         ostart_off_ff <= ostart_off_in;
         olen_ff       <= olen_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 16'd0) else $error("line count reached zero");
   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      col_ff != 16'd0) else $error("column count reached zero");
   a_open_below_limit: assert property (@(posedge clock) disable iff (reset)
      {1'b0, olen_ff} < 9'(LEN_LIMIT)) else $error("open token at length limit");
   a_idle_nothing_open: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> olen_ff == 8'd0) else $error("token open while idle");
`endif

endmodule

// ----- rtl/bts_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_queue
// Short first-in first-out queue of token entries between front and back.
// ----------------------------------------------------------------------------
module bts_queue
   import bts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output entry_type  head
);

   entry_type                 slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      QUEUE_PTR_BITS'(wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_BITS-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/bts_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_back
// Unpacks queue entries into single token transfers through an output
// register.
// ----------------------------------------------------------------------------
module bts_back
   import bts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic [23:0] rsp_token_start,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_length_overflow,
   output logic        rsp_last_of_run
);

   logic      valid_ff, valid_in;
   logic      sub_ff, sub_in;
   token_type tok_ff, tok_in;
   logic      last_ff, last_in;
   logic      load;
   logic      last_slot;

   assign load      = (!valid_ff || !rsp_stall) && !empty;
   assign last_slot = sub_ff || (head.count == 2'd1);
   assign pop       = load && last_slot;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         tok_in   = sub_ff ? head.second : head.first;
         last_in  = last_slot;
         sub_in   = !last_slot;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_token_kind      = tok_ff.kind;
   assign rsp_token_line      = tok_ff.line;
   assign rsp_token_column    = tok_ff.column;
   assign rsp_token_start     = tok_ff.start;
   assign rsp_token_length    = tok_ff.length;
   assign rsp_length_overflow = tok_ff.overflow;
   assign rsp_last_of_run     = last_ff;

`ifndef NO_ASSERTIONS
   a_sub_needs_pair: assert property (@(posedge clock) disable iff (reset)
      sub_ff && !empty |-> head.count == 2'd2) else $error("second slot of single entry");
   a_no_empty_entry: assert property (@(posedge clock) disable iff (reset)
      !empty |-> head.count != 2'd0) else $error("queue entry without tokens");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && tok_ff.kind == KIND_END |-> last_ff) else $error("end token not last");
`endif

endmodule

// ----- rtl/byte_stream_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_tokenizer
// Expression lexer: one text byte per transfer in, one token per transfer out.
// ----------------------------------------------------------------------------
// usage
//   req channel: one text byte per transfer on req_char_byte; byte zero ends
//   the text, flushes any open token, sends an end token and restarts counts
//   rsp channel: one token per transfer, kind, line, column, start offset,
//   length and overflow flag; rsp_last_of_run marks the last token of a byte
//   throughput: one byte per cycle while the queue is not full; a byte that
//   closes a token and makes a second one (operator, end, length cut) needs
//   two rsp transfers; a byte's first token is written into the queue and
//   then loaded into the rsp output register when rsp does not stall
//   the front tracks position and open token, a four-entry queue holds the
//   packed tokens, and the back unpacks them into the rsp output register
//   receiver stall: rsp holds its token; req_stall rises once the queue is
//   full and bytes that cause no token still wait for room
//   reset: synchronous, clears counts to line 1, column 1, offset 0 and
//   drops everything queued
// ----------------------------------------------------------------------------
module byte_stream_tokenizer
   import bts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic [23:0] rsp_token_start,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_length_overflow,
   output logic        rsp_last_of_run
);

   logic      push, pop, full, empty;
   entry_type push_entry, head;

   bts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .queue_full    (full),
      .push          (push),
      .push_entry    (push_entry)
   );

   bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   bts_back u_back (
      .clock               (clock),
      .reset               (reset),
      .empty               (empty),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_token_line      (rsp_token_line),
      .rsp_token_column    (rsp_token_column),
      .rsp_token_start     (rsp_token_start),
      .rsp_token_length    (rsp_token_length),
      .rsp_length_overflow (rsp_length_overflow),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule
